// ===== rtl/wpm_pkg.sv =====
package wpm_pkg;

  // width of the character field on the request
  localparam int CODE_W = 16;

  // wildcard characters of the pattern
  localparam logic [7:0] WILD_STAR = 8'h2A;
  localparam logic [7:0] WILD_ONE  = 8'h3F;

  // ascii case folding
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic               first_char;
    logic               last_char;
    logic [CODE_W-1:0]  char_code;
  } req_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } res_t;

endpackage

// ===== rtl/wildcard_pattern_matcher.sv =====
// channel | direction | payload | handshake
// req     | in        | req_t   | req_valid / req_stall
// res     | out       | res_t   | res_valid / res_stall
//
// one request per cycle while req_stall is low, pattern and text characters alike
// a result appears in the cycle after its last text character is taken
// the active-position update is one carry chain over PATTERN_MAX+1 bits
// reset empties the pattern, clears the active vector and the result valid flag
// req_stall is high only while a result sits in the output register and is stalled
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = 32,
  parameter int CHAR_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wpm_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output wpm_pkg::res_t res
);
  import wpm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // pattern storage, no reset: only entries below len are ever looked at
  logic [CHAR_BITS-1:0] pattern [PATTERN_MAX];
  logic [LEN_W-1:0]     len;
  logic                 overflow;
  // every loaded character so far is a star
  logic                 lead_star;
  // active vector at the start of a text: position 0 plus the position after each leading star
  logic [PATTERN_MAX:0] start_vec;
  logic [PATTERN_MAX:0] active;

  logic [CHAR_BITS-1:0] char_raw;
  logic [CHAR_BITS-1:0] char_fold;
  logic                 char_star;
  logic                 req_take;
  logic                 load_take;
  logic                 text_take;

  logic [LEN_W-1:0]     base_len;
  logic                 base_ovf;
  logic                 base_lead;
  logic [PATTERN_MAX:0] base_start;
  logic                 has_room;

  logic [LEN_W-1:0]     len_next;
  logic                 overflow_next;
  logic                 lead_star_next;
  logic [PATTERN_MAX:0] start_vec_next;

  logic [PATTERN_MAX:0] step_in;
  logic [PATTERN_MAX:0] active_next;

  // request accepted unless the output register holds a stalled result
  assign req_stall = res_valid & res_stall;
  assign req_take  = req_valid & ~req_stall;
  assign load_take = req_take & (req.operation == OP_PATTERN);
  assign text_take = req_take & (req.operation == OP_TEXT);

  // bring the character field to the stored width
  generate
    if (CHAR_BITS > CODE_W) begin : g_widen
      assign char_raw = {{(CHAR_BITS - CODE_W){1'b0}}, req.char_code};
    end else begin : g_narrow
      assign char_raw = req.char_code[CHAR_BITS-1:0];
    end
  endgenerate

  // fold A-Z to a-z
  always_comb begin
    if ((char_raw >= CHAR_BITS'(UPPER_A)) && (char_raw <= CHAR_BITS'(UPPER_Z))) begin
      char_fold = char_raw | CHAR_BITS'(CASE_BIT);
    end else begin
      char_fold = char_raw;
    end
  end

  assign char_star = (char_fold == CHAR_BITS'(WILD_STAR));

  // pattern load: a first character restarts the pattern before it is stored
  always_comb begin
    if (req.first_char) begin
      base_len   = '0;
      base_ovf   = 1'b0;
      base_lead  = 1'b1;
      base_start = (PATTERN_MAX + 1)'(1);
    end else begin
      base_len   = len;
      base_ovf   = overflow;
      base_lead  = lead_star;
      base_start = start_vec;
    end
    has_room = (base_len < LEN_W'(PATTERN_MAX));

    len_next       = base_len;
    overflow_next  = base_ovf;
    lead_star_next = base_lead;
    start_vec_next = base_start;
    if (has_room) begin
      len_next       = base_len + LEN_W'(1);
      lead_star_next = base_lead & char_star;
      // a run of leading stars makes the position after it reachable
      if (base_lead && char_star) begin
        start_vec_next[base_len + LEN_W'(1)] = 1'b1;
      end
    end else begin
      // characters past capacity are dropped
      overflow_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_take && has_room) begin
      pattern[base_len[IDX_W-1:0]] <= char_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      overflow  <= 1'b0;
      lead_star <= 1'b1;
      start_vec <= (PATTERN_MAX + 1)'(1);
    end else if (load_take) begin
      len       <= len_next;
      overflow  <= overflow_next;
      lead_star <= lead_star_next;
      start_vec <= start_vec_next;
    end
  end

  // text: a first character starts from the precomputed start vector
  assign step_in = req.first_char ? start_vec : active;

  wpm_step #(
    .PATTERN_MAX (PATTERN_MAX),
    .CHAR_BITS   (CHAR_BITS),
    .LEN_W       (LEN_W)
  ) u_step (
    .pattern     (pattern),
    .len         (len),
    .char_in     (char_fold),
    .active      (step_in),
    .active_next (active_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (text_take) begin
      active <= active_next;
    end
  end

  // result register: filled on the last text character, emptied when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (text_take && req.last_char) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take && req.last_char) begin
      res.matched          <= ~overflow & active_next[len];
      res.pattern_overflow <= overflow;
    end
  end

  // pattern length never runs past capacity
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  // overflow only once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (len == LEN_W'(PATTERN_MAX)))
    else $error("overflow flag with room left");

  // a text always starts at pattern position zero
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    start_vec[0])
    else $error("start vector lost position zero");

  // an overflowed pattern never reports a match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.matched && res.pattern_overflow))
    else $error("match reported with overflow");

  // a taken last text character produces a pending result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (text_take && req.last_char) |=> res_valid)
    else $error("result missing after last character");

endmodule

// ===== rtl/wpm_step.sv =====
module wpm_step #(
  parameter int PATTERN_MAX = 32,
  parameter int CHAR_BITS   = 16,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic [CHAR_BITS-1:0] pattern [PATTERN_MAX],
  input  logic [LEN_W-1:0]     len,
  input  logic [CHAR_BITS-1:0] char_in,
  input  logic [PATTERN_MAX:0] active,
  output logic [PATTERN_MAX:0] active_next
);
  import wpm_pkg::*;

  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX:0]   adv;
  logic [PATTERN_MAX:0]   star_ext;
  logic [PATTERN_MAX:0]   run_sum;

  // per position: star, or a single-character step that consumes char_in
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      logic in_pat;
      logic is_star;
      logic is_one;
      in_pat  = (LEN_W'(i) < len);
      is_star = (pattern[i] == CHAR_BITS'(WILD_STAR));
      is_one  = (pattern[i] == CHAR_BITS'(WILD_ONE));
      star[i] = in_pat & is_star;
      hit[i]  = in_pat & ~is_star & (is_one | (pattern[i] == char_in));
    end
  end

  // a star stays put, a matching character moves one position up
  assign adv = {1'b0, active[PATTERN_MAX-1:0] & star}
             | {active[PATTERN_MAX-1:0] & hit, 1'b0};

  // star closure as a carry chain: the carry from an active star runs
  // through the following stars and lands on the first non-star position
  assign star_ext    = {1'b0, star};
  assign run_sum     = star_ext + (adv & star_ext);
  assign active_next = adv | (run_sum ^ star_ext);

endmodule
